@@ hw/rtl/gsfs_pkg.sv @@
// Shared types, constants and tables for the Gaussian source flux sum unit.
package gsfs_pkg;

  localparam int OP_W   = 64;
  localparam int PROD_W = 128;
  localparam int CNT_W  = 7;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;
  localparam logic [17:0] GAUSS_C_Q16 = 18'd233289;
  localparam logic [9:0]  MM_PER_M    = 10'd1000;
  localparam logic [30:0] ONE_Q30     = 31'h40000000;
  localparam logic [36:0] ARG_LIMIT   = 37'h400000000;
  localparam logic [31:0] X_CAP       = 32'hFFFFFFFF;
  localparam logic [27:0] ACC_MAX     = 28'hFFFFFFF;
  localparam logic [31:0] IW_RESET    = 32'd1835008;
  localparam logic [2:0]  SQUARINGS   = 3'd5;

  typedef struct packed {
    logic             start;
    logic [OP_W-1:0]  a;
    logic [OP_W-1:0]  b;
    logic [CNT_W-1:0] nbits;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [OP_W-1:0]  dividend;
    logic [9:0]       divisor;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL_W,
    ST_MUL_VC,
    ST_MUL_US,
    ST_MUL_UC,
    ST_MUL_VS,
    ST_MUL_PW,
    ST_DIV_P,
    ST_MUL_QW,
    ST_DIV_Q,
    ST_MUL_R,
    ST_MUL_PP,
    ST_MUL_QQ,
    ST_MUL_C,
    ST_EXP_CHK,
    ST_MUL_TE,
    ST_DIV_K,
    ST_MUL_SQ,
    ST_MUL_F,
    ST_FINISH
  } seq_state_t;

  // arctangent of 2^-i in binary turns, scaled by 2^32
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:    r = 30'h20000000;
      5'd1:    r = 30'h12E4051E;
      5'd2:    r = 30'h09FB385B;
      5'd3:    r = 30'h051111D4;
      5'd4:    r = 30'h028B0D43;
      5'd5:    r = 30'h0145D7E1;
      5'd6:    r = 30'h00A2F61E;
      5'd7:    r = 30'h00517C55;
      5'd8:    r = 30'h0028BE53;
      5'd9:    r = 30'h00145F2F;
      5'd10:   r = 30'h000A2F98;
      5'd11:   r = 30'h000517CC;
      5'd12:   r = 30'h00028BE6;
      5'd13:   r = 30'h000145F3;
      5'd14:   r = 30'h0000A2FA;
      5'd15:   r = 30'h0000517D;
      5'd16:   r = 30'h000028BE;
      5'd17:   r = 30'h0000145F;
      5'd18:   r = 30'h00000A30;
      5'd19:   r = 30'h00000518;
      5'd20:   r = 30'h0000028C;
      5'd21:   r = 30'h00000146;
      5'd22:   r = 30'h000000A3;
      5'd23:   r = 30'h00000051;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/gaussian_source_flux_sum_unit.sv @@
// Top level: visibility flux sum of elliptical Gaussian components on one baseline.
//
// Input beats on s_axis carry a baseline (u,v) and one source component; tlast
// marks the final component of an evaluation. Each beat adds the component
// flux weighted by exp(-c*(p^2+q^2)) to a saturating Q12.16 accumulator; on the
// tlast beat the total goes out on m_axis as one beat and the sum is cleared.
// Components beyond MAX_COMPONENTS in one evaluation add nothing.
// cfg_valid/cfg_data writes the inverse wavelength register (Q16 per metre);
// write it only while the unit is idle.
// The unit takes one component at a time; the work runs on the shared bit-serial
// multiplier and divider, and the exponential's Taylor series costs one multiply
// and one divide per term.
// Saturated distances and out-of-range exponents skip work; a component past
// the limit goes straight to the finish state without any arithmetic.
// s_axis_tready is high only while idle. The result sits in an output register,
// so a stalled receiver delays the unit only once a second total is ready.
// Reset (rst, synchronous) clears the sum, the component count and the output,
// and restores the inverse wavelength to 28 per metre.
module gaussian_source_flux_sum_unit
  import gsfs_pkg::*;
#(
  parameter int MAX_COMPONENTS    = 16,
  parameter int APPROX_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // baseline_u[35:0], baseline_v[71:36], component_flux[95:72],
  // major_axis[127:96], axial_ratio[147:128], position_angle[163:148], zero pad
  input  logic [167:0] s_axis_tdata,
  input  logic         s_axis_tlast,  // last_component
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // observed_flux[27:0], zero pad
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  localparam int CNTC_W       = $clog2(MAX_COMPONENTS + 1);
  localparam int CORDIC_STEPS = (APPROX_ITERATIONS < 24) ? APPROX_ITERATIONS : 24;

  seq_state_t state, state_next;
  logic       started;

  // registers
  logic [31:0]        iw;
  logic [CNTC_W-1:0]  count;
  logic [27:0]        acc;
  logic               m_valid;
  logic [27:0]        m_data;
  logic [4:0]         k_r;
  logic [2:0]         sq_cnt;

  logic signed [35:0] u_r;
  logic signed [35:0] v_r;
  logic [23:0]        flux_r;
  logic [31:0]        axis_r;
  logic [19:0]        ratio_r;
  logic [15:0]        angle_r;
  logic               last_r;
  logic [63:0]        w_r;
  logic signed [58:0] t0;
  logic signed [59:0] p_r;
  logic signed [59:0] q_r;
  logic [31:0]        xp;
  logic [31:0]        xq;
  logic [33:0]        sq_r;
  logic [34:0]        sum_r;
  logic [36:0]        arg_r;
  logic [29:0]        t_r;
  logic [30:0]        e_r;

  // units
  mul_req_t           mul_req;
  div_req_t           div_req;
  logic               mul_done;
  logic               div_done;
  logic [PROD_W-1:0]  mul_prod;
  logic [OP_W-1:0]    div_quot;
  logic               cor_start;
  logic               cor_done;
  logic signed [21:0] cos_q20;
  logic signed [21:0] sin_q20;

  // combinational helpers
  logic               accept;
  logic               emit;
  logic               op_done;
  logic               mul_neg;
  logic [35:0]        u_mag;
  logic [35:0]        v_mag;
  logic [21:0]        c_mag;
  logic [21:0]        s_mag;
  logic [59:0]        p_mag;
  logic [59:0]        q_mag;
  logic [58:0]        prod_mag;
  logic signed [58:0] term;
  logic               pw_cap;
  logic [28:0]        acc_sum;

  gsfs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (angle_r),
    .done    (cor_done),
    .cos_q20 (cos_q20),
    .sin_q20 (sin_q20)
  );

  gsfs_serial_mult u_mult (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  gsfs_serial_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'h0, m_data};
  assign emit          = (state == ST_FINISH) && last_r && (!m_valid || m_axis_tready);

  assign u_mag    = u_r[35] ? 36'(-u_r) : 36'(u_r);
  assign v_mag    = v_r[35] ? 36'(-v_r) : 36'(v_r);
  assign c_mag    = cos_q20[21] ? 22'(-cos_q20) : 22'(cos_q20);
  assign s_mag    = sin_q20[21] ? 22'(-sin_q20) : 22'(sin_q20);
  assign p_mag    = p_r[59] ? 60'(-p_r) : 60'(p_r);
  assign q_mag    = q_r[59] ? 60'(-q_r) : 60'(q_r);
  assign prod_mag = {1'b0, mul_prod[57:0]};
  assign term     = mul_neg ? -$signed(prod_mag) : $signed(prod_mag);
  // distance product of 2^114 or more saturates without dividing
  assign pw_cap   = (mul_prod[127:114] != '0);
  assign acc_sum  = {1'b0, acc} + {4'h0, mul_prod[54:30]};

  // operand selection and unit starts
  always_comb begin
    mul_req   = '0;
    div_req   = '0;
    mul_neg   = 1'b0;
    cor_start = 1'b0;
    op_done   = mul_done;
    unique case (state)
      ST_CORDIC: begin
        cor_start = !started;
        op_done   = cor_done;
      end
      ST_MUL_W: begin
        mul_req = '{!started, 64'(iw), 64'(axis_r), CNT_W'(32)};
      end
      ST_MUL_VC: begin
        mul_req = '{!started, 64'(v_mag), 64'(c_mag), CNT_W'(22)};
        mul_neg = v_r[35] ^ cos_q20[21];
      end
      ST_MUL_US: begin
        mul_req = '{!started, 64'(u_mag), 64'(s_mag), CNT_W'(22)};
        mul_neg = u_r[35] ^ sin_q20[21];
      end
      ST_MUL_UC: begin
        mul_req = '{!started, 64'(u_mag), 64'(c_mag), CNT_W'(22)};
        mul_neg = u_r[35] ^ cos_q20[21];
      end
      ST_MUL_VS: begin
        mul_req = '{!started, 64'(v_mag), 64'(s_mag), CNT_W'(22)};
        mul_neg = v_r[35] ^ sin_q20[21];
      end
      ST_MUL_PW: begin
        mul_req = '{!started, 64'(p_mag), w_r, CNT_W'(64)};
      end
      ST_MUL_QW: begin
        mul_req = '{!started, 64'(q_mag), w_r, CNT_W'(64)};
      end
      ST_DIV_P, ST_DIV_Q: begin
        div_req = '{!started, 64'(mul_prod[113:54]), MM_PER_M, CNT_W'(60)};
        op_done = div_done;
      end
      ST_MUL_R: begin
        mul_req = '{!started, 64'(xq), 64'(ratio_r), CNT_W'(20)};
      end
      ST_MUL_PP: begin
        mul_req = '{!started, 64'(xp), 64'(xp), CNT_W'(32)};
      end
      ST_MUL_QQ: begin
        mul_req = '{!started, 64'(xq), 64'(xq), CNT_W'(32)};
      end
      ST_MUL_C: begin
        mul_req = '{!started, 64'(sum_r), 64'(GAUSS_C_Q16), CNT_W'(18)};
      end
      ST_MUL_TE: begin
        mul_req = '{!started, 64'(t_r), 64'(e_r), CNT_W'(31)};
      end
      ST_DIV_K: begin
        div_req = '{!started, 64'(mul_prod[59:30]), {5'h0, k_r}, CNT_W'(30)};
        op_done = div_done;
      end
      ST_MUL_SQ: begin
        mul_req = '{!started, 64'(e_r), 64'(e_r), CNT_W'(31)};
      end
      ST_MUL_F: begin
        mul_req = '{!started, 64'(e_r), 64'(flux_r), CNT_W'(24)};
      end
      default: begin
        op_done = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (count < CNTC_W'(MAX_COMPONENTS)) ? ST_CORDIC : ST_FINISH;
        end
      end
      ST_CORDIC:  if (op_done) state_next = ST_MUL_W;
      ST_MUL_W:   if (op_done) state_next = ST_MUL_VC;
      ST_MUL_VC:  if (op_done) state_next = ST_MUL_US;
      ST_MUL_US:  if (op_done) state_next = ST_MUL_UC;
      ST_MUL_UC:  if (op_done) state_next = ST_MUL_VS;
      ST_MUL_VS:  if (op_done) state_next = ST_MUL_PW;
      ST_MUL_PW:  if (op_done) state_next = pw_cap ? ST_MUL_QW : ST_DIV_P;
      ST_DIV_P:   if (op_done) state_next = ST_MUL_QW;
      ST_MUL_QW:  if (op_done) state_next = pw_cap ? ST_MUL_R : ST_DIV_Q;
      ST_DIV_Q:   if (op_done) state_next = ST_MUL_R;
      ST_MUL_R:   if (op_done) state_next = ST_MUL_PP;
      ST_MUL_PP:  if (op_done) state_next = ST_MUL_QQ;
      ST_MUL_QQ:  if (op_done) state_next = ST_MUL_C;
      ST_MUL_C:   if (op_done) state_next = ST_EXP_CHK;
      ST_EXP_CHK: state_next = (arg_r > ARG_LIMIT) ? ST_FINISH : ST_MUL_TE;
      ST_MUL_TE:  if (op_done) state_next = ST_DIV_K;
      ST_DIV_K: begin
        if (op_done) state_next = (k_r == 5'd1) ? ST_MUL_SQ : ST_MUL_TE;
      end
      ST_MUL_SQ: begin
        if (op_done && sq_cnt == SQUARINGS - 3'd1) state_next = ST_MUL_F;
      end
      ST_MUL_F:   if (op_done) state_next = ST_FINISH;
      ST_FINISH: begin
        if (!last_r || emit) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
      iw      <= IW_RESET;
      count   <= '0;
      acc     <= '0;
      m_valid <= 1'b0;
      k_r     <= '0;
      sq_cnt  <= '0;
    end else begin
      state <= state_next;
      if (mul_req.start || div_req.start || cor_start) begin
        started <= 1'b1;
      end else if (op_done) begin
        started <= 1'b0;
      end
      if (cfg_valid) begin
        iw <= cfg_data;
      end
      if (accept && count < CNTC_W'(MAX_COMPONENTS)) begin
        count <= count + 1'b1;
      end
      if (state == ST_EXP_CHK) begin
        k_r    <= 5'(APPROX_ITERATIONS);
        sq_cnt <= '0;
      end
      if (state == ST_DIV_K && op_done) begin
        k_r <= k_r - 1'b1;
      end
      if (state == ST_MUL_SQ && op_done) begin
        sq_cnt <= sq_cnt + 1'b1;
      end
      if (state == ST_MUL_F && op_done) begin
        acc <= acc_sum[28] ? ACC_MAX : acc_sum[27:0];
      end
      if (emit) begin
        m_valid <= 1'b1;
        acc     <= '0;
        count   <= '0;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      u_r     <= $signed(s_axis_tdata[35:0]);
      v_r     <= $signed(s_axis_tdata[71:36]);
      flux_r  <= s_axis_tdata[95:72];
      axis_r  <= s_axis_tdata[127:96];
      ratio_r <= s_axis_tdata[147:128];
      angle_r <= s_axis_tdata[163:148];
      last_r  <= s_axis_tlast;
    end
    if (emit) begin
      m_data <= acc;
    end
    if (state == ST_EXP_CHK) begin
      t_r <= arg_r[34:5];
      e_r <= ONE_Q30;
    end
    if (op_done) begin
      unique case (state)
        ST_MUL_W:  w_r <= mul_prod[63:0];
        ST_MUL_VC: t0 <= term;
        ST_MUL_US: p_r <= 60'(t0) + 60'(term);
        ST_MUL_UC: t0 <= term;
        ST_MUL_VS: q_r <= 60'(t0) - 60'(term);
        ST_MUL_PW: if (pw_cap) xp <= X_CAP;
        ST_DIV_P:  xp <= (div_quot[63:32] != '0) ? X_CAP : div_quot[31:0];
        ST_MUL_QW: if (pw_cap) xq <= X_CAP;
        ST_DIV_Q:  xq <= (div_quot[63:32] != '0) ? X_CAP : div_quot[31:0];
        ST_MUL_R:  xq <= (mul_prod[51:48] != '0) ? X_CAP : mul_prod[47:16];
        ST_MUL_PP: sq_r <= mul_prod[63:30];
        ST_MUL_QQ: sum_r <= {1'b0, sq_r} + {1'b0, mul_prod[63:30]};
        ST_MUL_C:  arg_r <= mul_prod[52:16];
        ST_DIV_K:  e_r <= ONE_Q30 - div_quot[30:0];
        ST_MUL_SQ: e_r <= mul_prod[60:30];
        default: begin
        end
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTC_W'(MAX_COMPONENTS))
    else $error("component count beyond limit");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted beat did not start work");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_req.start && div_req.start))
    else $error("multiplier and divider started together");

  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_valid && acc == '0 && count == '0)
    else $error("sum not cleared on emit");

endmodule

@@ hw/rtl/gsfs_serial_mult.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module gsfs_serial_mult
  import gsfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mul_req_t          req,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [OP_W-1:0]  a_r;
  logic [OP_W-1:0]  b_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_r  <= req.b << (CNT_W'(OP_W) - req.nbits);
      prod <= '0;
    end else if (busy) begin
      prod <= {prod[PROD_W-2:0], 1'b0} + (b_r[OP_W-1] ? {{(PROD_W-OP_W){1'b0}}, a_r} : '0);
      b_r  <= {b_r[OP_W-2:0], 1'b0};
    end
  end

endmodule

@@ hw/rtl/gsfs_serial_div.sv @@
// Restoring divider by a small constant-width divisor, one quotient bit per cycle.
module gsfs_serial_div
  import gsfs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  div_req_t        req,
  output logic            done,
  output logic [OP_W-1:0] quot
);

  logic [OP_W-1:0]  dvd;
  logic [9:0]       dvs;
  logic [9:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [10:0]      trial;
  logic             ge;
  logic [10:0]      diff;

  assign trial = {rem, dvd[OP_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd  <= req.dividend << (CNT_W'(OP_W) - req.nbits);
      dvs  <= req.divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd  <= {dvd[OP_W-2:0], 1'b0};
      rem  <= ge ? diff[9:0] : trial[9:0];
      quot <= {quot[OP_W-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/gsfs_cordic.sv @@
// Iterative CORDIC giving sine and cosine in Q20 of a binary-turn angle.
module gsfs_cordic
  import gsfs_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [21:0] cos_q20,
  output logic signed [21:0] sin_q20
);

  logic signed [32:0] x;
  logic signed [32:0] y;
  logic signed [32:0] z;
  logic [4:0]         idx;
  logic [1:0]         quad;
  logic               busy;
  logic [15:0]        ang_off;
  logic [1:0]         quad_in;
  logic [15:0]        r16;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [32:0] at;
  logic signed [32:0] xr;
  logic signed [32:0] yr;
  logic signed [21:0] xq;
  logic signed [21:0] yq;

  // fold into +-1/8 turn by whole quarter turns
  assign ang_off = angle + 16'h2000;
  assign quad_in = ang_off[15:14];
  assign r16     = angle - {quad_in, 14'h0};

  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = $signed({3'b000, atan_turn(idx)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == 5'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= $signed({r16[15], r16, 16'h0});
      quad <= quad_in;
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign xr = x >>> 10;
  assign yr = y >>> 10;
  assign xq = xr[21:0];
  assign yq = yr[21:0];

  always_comb begin
    unique case (quad)
      2'd0: begin
        cos_q20 = xq;
        sin_q20 = yq;
      end
      2'd1: begin
        cos_q20 = -yq;
        sin_q20 = xq;
      end
      2'd2: begin
        cos_q20 = -xq;
        sin_q20 = -yq;
      end
      default: begin
        cos_q20 = yq;
        sin_q20 = -xq;
      end
    endcase
  end

endmodule

@@ test/gaussian_source_flux_sum_unit_tb.sv @@
// Testbench for the Gaussian source flux sum unit: directed, config and random checks.
`timescale 1ns / 1ps

module gaussian_source_flux_sum_unit_tb
  import gsfs_pkg::*;
();

  localparam int MAX_COMP = 16;
  localparam int TERMS    = 16;

  typedef struct {
    logic signed [35:0] u;
    logic signed [35:0] v;
    logic [23:0]        flux;
    logic [31:0]        axis;
    logic [19:0]        ratio;
    logic [15:0]        angle;
    logic               last;
  } component_t;

  // arctangent of 2^-i in turns scaled by 2^32
  localparam longint ATAN_TURNS [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;

  // predictor state
  logic [31:0] inv_wavelength;
  logic [27:0] flux_sum;
  int          comps_taken;
  logic [27:0] expected_totals[$];

  int beats_sent;
  int totals_checked;
  int mismatches;
  int cfg_writes;
  bit rx_stall_on;

  gaussian_source_flux_sum_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor(|d| * w / 2^54 / 1000) in Q30, capped at 32 bits
  function automatic logic [31:0] baseline_scale(input logic [63:0] mag, input logic [63:0] w);
    logic [127:0] prod;
    logic [127:0] quot;
    prod = {64'd0, mag} * {64'd0, w};
    if (prod[127:114] != 0) return X_CAP;
    quot = (prod >> 54) / 1000;
    return (quot > 128'hFFFFFFFF) ? X_CAP : quot[31:0];
  endfunction

  // CORDIC rotation after quarter-turn folding, Q20 outputs
  function automatic void angle_to_cos_sin(input logic [15:0] ang, output longint c,
                                           output longint s);
    logic [31:0] t, rr, quad;
    longint x, y, z, xs, ys;
    t    = {ang, 16'd0};
    quad = ((t + 32'h20000000) >> 30) & 32'd3;
    rr   = t - (quad << 30);
    z    = longint'(signed'(rr));
    x    = 64'h26DD3B6A;
    y    = 0;
    for (int i = 0; i < TERMS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
      end
    end
    x = x >>> 10;
    y = y >>> 10;
    case (quad)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // exp(-arg) for Q30 arg: Taylor series on arg/32 then five squarings
  function automatic logic [63:0] gaussian_weight(input logic [63:0] arg);
    logic [63:0] t, e;
    if (arg > (64'd16 << 30)) return 0;
    t = arg >> 5;
    e = 64'd1 << 30;
    for (int k = TERMS; k >= 1; k--) e = (64'd1 << 30) - ((t * e) >> 30) / k;
    for (int k = 0; k < 5; k++) e = (e * e) >> 30;
    return e;
  endfunction

  // fold one accepted component into the running sum; queue a total on last
  function automatic void accumulate_component(input component_t cp);
    longint c, s, p, q;
    logic [63:0] w, xp, xq, pm, qm, total, arg, term;
    if (comps_taken < MAX_COMP) begin
      angle_to_cos_sin(cp.angle, c, s);
      p  = longint'(cp.v) * c + longint'(cp.u) * s;
      q  = longint'(cp.u) * c - longint'(cp.v) * s;
      pm = (p < 0) ? -p : p;
      qm = (q < 0) ? -q : q;
      w  = {32'd0, inv_wavelength} * {32'd0, cp.axis};
      xp = baseline_scale(pm, w);
      xq = (baseline_scale(qm, w) * cp.ratio) >> 16;
      if (xq > 64'hFFFFFFFF) xq = 64'hFFFFFFFF;
      total = ((xp * xp) >> 30) + ((xq * xq) >> 30);
      arg   = (total * 233289) >> 16;
      term  = ({40'd0, cp.flux} * gaussian_weight(arg)) >> 30;
      term  = term + flux_sum;
      flux_sum = (term > 64'h0FFFFFFF) ? ACC_MAX : term[27:0];
      comps_taken++;
    end
    if (cp.last) begin
      expected_totals.push_back(flux_sum);
      flux_sum    = '0;
      comps_taken = 0;
    end
  endfunction

  // one component beat; gap = idle cycles after it (0 keeps tvalid high)
  task automatic send_component(input component_t cp, input int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, cp.angle, cp.ratio, cp.axis, cp.flux, cp.v, cp.u};
    s_axis_tlast  <= cp.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    accumulate_component(cp);
    beats_sent++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_totals();
    s_axis_tvalid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_inv_wavelength(input logic [31:0] val);
    drain_totals();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    inv_wavelength = val;
    cfg_writes++;
  endtask

  function automatic component_t random_component(input bit last);
    component_t cp;
    logic signed [35:0] r;
    if ($urandom_range(0, 3) == 0) begin
      // raw bits everywhere
      cp.u     = 36'({$urandom, $urandom});
      cp.v     = 36'({$urandom, $urandom});
      cp.flux  = 24'($urandom);
      cp.axis  = $urandom;
      cp.ratio = 20'($urandom);
    end else begin
      // shrink sizes so the weight lands in its interesting range
      r = 36'({$urandom, $urandom}); cp.u = r >>> $urandom_range(0, 35);
      r = 36'({$urandom, $urandom}); cp.v = r >>> $urandom_range(0, 35);
      cp.flux  = 24'($urandom >> $urandom_range(0, 12));
      cp.axis  = $urandom >> $urandom_range(0, 31);
      cp.ratio = 20'($urandom_range(0, 1) ? 32'h10000 - $urandom_range(0, 65535)
                                          : $urandom);
    end
    cp.angle = 16'($urandom);
    cp.last  = last;
    return cp;
  endfunction

  function automatic component_t make_component(input logic signed [35:0] u,
      input logic signed [35:0] v, input logic [23:0] flux, input logic [31:0] axis,
      input logic [19:0] ratio, input logic [15:0] angle, input bit last);
    component_t cp;
    cp.u = u; cp.v = v; cp.flux = flux; cp.axis = axis;
    cp.ratio = ratio; cp.angle = angle; cp.last = last;
    return cp;
  endfunction

  // field extremes, all quadrants of angle, zero weight and unit weight
  task automatic test_directed();
    send_component(make_component(0, 0, 24'hFFFFFF, 0, 0, 0, 1), 0);
    send_component(make_component(36'h7FFFFFFFF, 36'h800000000, 24'hFFFFFF, 32'hFFFFFFFF,
                                  20'hFFFFF, 16'hFFFF, 1), 2);
    send_component(make_component(-1, 1, 24'h010000, 1000, 20'h10000, 16'h4000, 0), 0);
    send_component(make_component(5000, -7000, 24'h020000, 32'h00100000, 20'h08000,
                                  16'h8000, 0), 0);
    send_component(make_component(-123456, 654321, 24'h030000, 32'h00010000, 20'h10000,
                                  16'hC000, 0), 0);
    send_component(make_component(100000, 100000, 24'h040000, 32'h00001000, 20'h20000,
                                  16'h2000, 1), 3);
    // overfull evaluation: only the first MAX_COMP count, sum near the ceiling
    for (int i = 0; i < MAX_COMP + 3; i++)
      send_component(make_component(0, 0, 24'hFFFFFF, 0, 20'hFFFFF, 16'(i * 3000),
                                    i == MAX_COMP + 2), 0);
    drain_totals();
  endtask

  task automatic test_wavelength_settings();
    component_t cp;
    logic [31:0] settings [4] = '{32'd0, 32'hFFFFFFFF, 32'd1, $urandom};
    foreach (settings[i]) begin
      write_inv_wavelength(settings[i]);
      for (int n = 0; n < 12; n++) begin
        cp = random_component(n % 4 == 3);
        send_component(cp, $urandom_range(0, 1) ? 0 : $urandom_range(1, 5));
      end
    end
    write_inv_wavelength(32'd1835008);
  endtask

  // evaluations of random length, a few over the component limit
  task automatic test_random_evaluations(input int n_items);
    int sent, len, burst, gap;
    burst = 0;
    sent  = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_COMP, MAX_COMP + 6)
                                         : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst--;
        send_component(random_component(i == len - 1), (burst == 0) ? gap : 0);
        sent++;
      end
      if (sent % 400 < len) begin
        drain_totals();
        write_inv_wavelength(($urandom_range(0, 1) ? $urandom : $urandom >> 8));
      end
    end
    drain_totals();
  endtask

  // receiver: long stretches of ready, then bursts of random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_stall_on   <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) rx_stall_on <= ~rx_stall_on;
      m_axis_tready <= rx_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_totals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected total beat: %h", m_axis_tdata[27:0]);
      end else begin
        if (m_axis_tdata[27:0] !== expected_totals[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("total mismatch: expected %h, got %h", expected_totals[0],
                     m_axis_tdata[27:0]);
        end
        void'(expected_totals.pop_front());
        totals_checked++;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    inv_wavelength = 32'd1835008;
    flux_sum       = '0;
    comps_taken    = 0;
    beats_sent     = 0;
    totals_checked = 0;
    mismatches     = 0;
    cfg_writes     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_wavelength_settings();
    test_random_evaluations(1650);
    repeat (20) @(posedge clk);

    $display("Sent %0d component beats, checked %0d totals, %0d wavelength writes.",
             beats_sent, totals_checked, cfg_writes);
    if (mismatches == 0 && expected_totals.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d totals outstanding", mismatches,
               expected_totals.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/gsfs_pkg.sv
hw/rtl/gsfs_serial_mult.sv
hw/rtl/gsfs_serial_div.sv
hw/rtl/gsfs_cordic.sv
hw/rtl/gaussian_source_flux_sum_unit.sv
test/gaussian_source_flux_sum_unit_tb.sv
